@@ src/bld_pkg.sv @@
// ============================================================================
// bld_pkg
// Shared types and constants for the bounded list deque.
// ============================================================================
package bld_pkg;

  localparam int DATA_W    = 32;
  localparam int FUNC_W    = 4;
  localparam int AMOUNT_W  = 7;
  localparam int ENTRIES_W = 7;
  localparam int STATUS_W  = 2;

  // Command codes carried in the func field.
  typedef enum logic [FUNC_W-1:0] {
    FN_ADD_FRONT  = 4'd0,
    FN_ADD_BACK   = 4'd1,
    FN_DROP_FRONT = 4'd2,
    FN_DROP_BACK  = 4'd3,
    FN_DROP_KEY   = 4'd4,
    FN_CLEAR      = 4'd5,
    FN_EMIT_ALL   = 4'd6,
    FN_EMIT_FIRST = 4'd7,
    FN_EMIT_LAST  = 4'd8
  } bld_func_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STS_DONE  = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } bld_status_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESP,
    ST_EMIT,
    ST_SCAN,
    ST_SHIFT
  } bld_state_e;

  typedef struct packed {
    logic [FUNC_W-1:0]          func;
    logic signed [DATA_W-1:0]   value;
    logic [AMOUNT_W-1:0]        amount;
  } bld_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]   item;
    logic                       has_item;
    logic                       is_last;
    logic [STATUS_W-1:0]        status;
    logic [ENTRIES_W-1:0]       entries;
  } bld_out_t;

endpackage

@@ src/bounded_list_deque_top.sv @@
// ============================================================================
// bounded_list_deque_top
// Bounded double-ended queue of signed 32-bit values with delete by key.
// ============================================================================
// Usage: a command transaction enters on in_valid_i/in_ready_o carrying func,
// value and amount. Each command produces one or more result transactions on
// out_valid_o/out_ready_i; the final one of a command has is_last set.
// The block handles one command at a time and raises in_ready_o only in its
// idle state, which it enters again once the command's last result is in the
// output register, so the next command can be taken while that result waits.
// Inserts, removals at the ends, clear and empty emits go from the idle state
// to the response state, which loads their result into the output register,
// and the next command is taken in the idle state after that.
// An emit of n entries presents them in order through the output register,
// one entry per cycle when the receiver never stalls. Delete by key reads the
// stored entries one per cycle through the memory read port until it finds
// the key, then moves every later entry down by one, one per cycle. Each held
// entry is either compared or moved once. The single memory port pair sets
// the pace of emits and deletes by key.
// Reset clears the head pointer, the count and the output valid; the entry
// store itself is not cleared. A stalled receiver simply holds the output
// register and the controller waits; nothing is lost or repeated.
// ============================================================================
module bounded_list_deque_top
  import bld_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  bld_in_t  in_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output bld_out_t out_o
);

  // Width of a physical slot index and of a logical count.
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW:0] DepthW = (CW + 1)'(DEPTH);

  // Maps a logical position (0 = front) to a physical slot. The sum stays
  // below twice DEPTH, so one compare and subtract does the modulo.
  function automatic logic [IW-1:0] wrap_pos(input logic [IW-1:0] head,
                                             input logic [CW-1:0] lpos);
    logic [CW:0] sum;
    sum = (CW + 1)'(head) + (CW + 1)'(lpos);
    if (sum >= DepthW) begin
      sum = sum - DepthW;
    end
    return sum[IW-1:0];
  endfunction

  bld_state_e  state_q, state_d;
  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic signed [DATA_W-1:0] key_q, key_d;
  logic [CW-1:0] cur_q, cur_d;    // logical position being walked
  logic [CW-1:0] last_q, last_d;  // last logical position of an emit
  logic          have_q, have_d;  // read data of the scan is valid
  bld_status_e   resp_q, resp_d;

  logic     out_valid_q, out_valid_d;
  bld_out_t out_q, out_d;

  // Memory port signals.
  logic                     mem_we;
  logic [IW-1:0]            mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic                     mem_re;
  logic [IW-1:0]            mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;

  // Shared conditions.
  logic          out_free;
  logic          list_full;
  logic          list_empty;
  logic [CW-1:0] amt_sat;
  logic [CW-1:0] emit_start;
  logic [CW-1:0] emit_n;
  logic          scan_match;
  logic          match_at_end;
  logic          shift_more;
  logic          emit_final;
  logic          push;
  bld_out_t      push_data;

  assign out_free   = !out_valid_q || out_ready_i;
  assign list_full  = (count_q == CW'(DEPTH));
  assign list_empty = (count_q == '0);
  assign amt_sat    = (in_i.amount > ENTRIES_W'(count_q)) ? count_q : in_i.amount[CW-1:0];

  // The entry range an emit command covers.
  always_comb begin
    emit_start = '0;
    emit_n     = count_q;
    priority if (in_i.func == FN_EMIT_FIRST) begin
      emit_n = amt_sat;
    end else if (in_i.func == FN_EMIT_LAST) begin
      emit_n     = amt_sat;
      emit_start = count_q - amt_sat;
    end else begin
      emit_n = count_q;
    end
  end

  // During the scan, cur_q is one past the position whose data is in mem_rdata.
  assign scan_match   = have_q && (mem_rdata == key_q);
  assign match_at_end = (cur_q >= count_q);
  assign shift_more   = ((CW + 1)'(cur_q) + (CW + 1)'(2)) < (CW + 1)'(count_q);
  assign emit_final   = (cur_q == last_q);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_i.func)
            FN_DROP_KEY: state_d = list_empty ? ST_RESP : ST_SCAN;
            FN_EMIT_ALL, FN_EMIT_FIRST, FN_EMIT_LAST: begin
              state_d = (emit_n == '0) ? ST_RESP : ST_EMIT;
            end
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free && emit_final) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        priority if (scan_match) begin
          state_d = match_at_end ? ST_RESP : ST_SHIFT;
        end else if (cur_q < count_q) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_SHIFT: begin
        if (!shift_more) begin
          state_d = ST_RESP;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath, memory control and result generation
  // --------------------------------------------------------------------------
  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    key_d     = key_q;
    cur_d     = cur_q;
    last_d    = last_q;
    have_d    = have_q;
    resp_d    = resp_q;
    mem_we    = 1'b0;
    mem_waddr = head_q;
    mem_wdata = in_i.value;
    mem_re    = 1'b0;
    mem_raddr = head_q;
    push      = 1'b0;
    push_data = '0;
    in_ready_o = (state_q == ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          resp_d = STS_DONE;
          unique case (in_i.func)
            FN_ADD_FRONT: begin
              if (list_full) begin
                resp_d = STS_FULL;
              end else begin
                head_d    = (head_q == '0) ? IW'(DEPTH - 1) : head_q - IW'(1);
                mem_we    = 1'b1;
                mem_waddr = head_d;
                count_d   = count_q + CW'(1);
              end
            end
            FN_ADD_BACK: begin
              if (list_full) begin
                resp_d = STS_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = wrap_pos(head_q, count_q);
                count_d   = count_q + CW'(1);
              end
            end
            FN_DROP_FRONT: begin
              if (list_empty) begin
                resp_d = STS_EMPTY;
              end else begin
                head_d  = wrap_pos(head_q, CW'(1));
                count_d = count_q - CW'(1);
              end
            end
            FN_DROP_BACK: begin
              if (list_empty) begin
                resp_d = STS_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
            FN_DROP_KEY: begin
              key_d  = in_i.value;
              cur_d  = '0;
              have_d = 1'b0;
              if (list_empty) begin
                resp_d = STS_EMPTY;
              end
            end
            FN_CLEAR: begin
              head_d  = '0;
              count_d = '0;
            end
            FN_EMIT_ALL, FN_EMIT_FIRST, FN_EMIT_LAST: begin
              if (emit_n == '0) begin
                resp_d = list_empty ? STS_EMPTY : STS_DONE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = wrap_pos(head_q, emit_start);
                cur_d     = emit_start;
                last_d    = emit_start + emit_n - CW'(1);
              end
            end
            default: resp_d = STS_DONE;
          endcase
        end
      end

      ST_RESP: begin
        if (out_free) begin
          push               = 1'b1;
          push_data.is_last  = 1'b1;
          push_data.status   = resp_q;
          push_data.entries  = ENTRIES_W'(count_q);
        end
      end

      ST_EMIT: begin
        // The read data always belongs to cur_q here; the next read is issued
        // only when this entry moves into the output register.
        if (out_free) begin
          push               = 1'b1;
          push_data.item     = mem_rdata;
          push_data.has_item = 1'b1;
          push_data.is_last  = emit_final;
          push_data.status   = STS_DONE;
          push_data.entries  = ENTRIES_W'(count_q);
          if (!emit_final) begin
            cur_d     = cur_q + CW'(1);
            mem_re    = 1'b1;
            mem_raddr = wrap_pos(head_q, cur_d);
          end
        end
      end

      ST_SCAN: begin
        priority if (scan_match) begin
          if (match_at_end) begin
            // The key was the back entry: nothing to move.
            count_d = count_q - CW'(1);
            resp_d  = STS_DONE;
          end else begin
            // Fetch the entry after the match; it goes into the match's slot.
            mem_re    = 1'b1;
            mem_raddr = wrap_pos(head_q, cur_q);
            cur_d     = cur_q - CW'(1);
          end
        end else if (cur_q < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = wrap_pos(head_q, cur_q);
          cur_d     = cur_q + CW'(1);
          have_d    = 1'b1;
        end else begin
          resp_d = STS_EMPTY;
        end
      end

      ST_SHIFT: begin
        // Write the entry read last cycle one place nearer the front, and
        // fetch the one after it. Reads and writes never hit the same slot.
        mem_we    = 1'b1;
        mem_waddr = wrap_pos(head_q, cur_q);
        mem_wdata = mem_rdata;
        if (shift_more) begin
          mem_re    = 1'b1;
          mem_raddr = wrap_pos(head_q, cur_q + CW'(2));
          cur_d     = cur_q + CW'(1);
        end else begin
          count_d = count_q - CW'(1);
          resp_d  = STS_DONE;
        end
      end

      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Output register: loads on a push, clears when the receiver takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_d       = push_data;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    cur_q  <= cur_d;
    last_q <= last_d;
    resp_q <= resp_d;
    out_q  <= out_d;
  end

  // Entry store.
  bld_ram #(
    .Depth (DEPTH),
    .AddrW (IW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

@@ src/bld_ram.sv @@
// ============================================================================
// bld_ram
// Simple dual-port memory: one write port, one read port, registered read.
// ============================================================================
module bld_ram
  import bld_pkg::*;
#(
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic signed [DATA_W-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic signed [DATA_W-1:0] rdata_o
);

  logic signed [DATA_W-1:0] mem [Depth];
  logic signed [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data is held until the next read enable.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
